/* sv/gn3d_pkg.sv */
// Shared types, constants and permutation table for the 3D gradient noise pipeline.
package gn3d_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int GRAD_FRAC_BITS  = 14;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int DOT_SHIFT       = GRAD_FRAC_BITS + COORD_FRAC_BITS - OUT_FRAC_BITS;
    localparam int N_STAGES        = 13;
    localparam int N_CORNERS       = 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef logic signed [15:0]          t_comp;
    typedef logic [7:0]                  t_idx;
    typedef logic [COORD_FRAC_BITS-1:0]  t_frac;
    typedef logic [COORD_FRAC_BITS:0]    t_weight;
    typedef logic signed [17:0]          t_val;
    typedef logic [N_STAGES-1:0]         t_stage_en;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
    } t_grad;

    localparam t_idx PERM_ROM [256] = '{
        8'd225, 8'd155, 8'd210, 8'd108, 8'd175, 8'd199, 8'd221, 8'd144,
        8'd203, 8'd116, 8'd70,  8'd213, 8'd69,  8'd158, 8'd33,  8'd252,
        8'd5,   8'd82,  8'd173, 8'd133, 8'd222, 8'd139, 8'd174, 8'd27,
        8'd9,   8'd71,  8'd90,  8'd246, 8'd75,  8'd130, 8'd91,  8'd191,
        8'd169, 8'd138, 8'd2,   8'd151, 8'd194, 8'd235, 8'd81,  8'd7,
        8'd25,  8'd113, 8'd228, 8'd159, 8'd205, 8'd253, 8'd134, 8'd142,
        8'd248, 8'd65,  8'd224, 8'd217, 8'd22,  8'd121, 8'd229, 8'd63,
        8'd89,  8'd103, 8'd96,  8'd104, 8'd156, 8'd17,  8'd201, 8'd129,
        8'd36,  8'd8,   8'd165, 8'd110, 8'd237, 8'd117, 8'd231, 8'd56,
        8'd132, 8'd211, 8'd152, 8'd20,  8'd181, 8'd111, 8'd239, 8'd218,
        8'd170, 8'd163, 8'd51,  8'd172, 8'd157, 8'd47,  8'd80,  8'd212,
        8'd176, 8'd250, 8'd87,  8'd49,  8'd99,  8'd242, 8'd136, 8'd189,
        8'd162, 8'd115, 8'd44,  8'd43,  8'd124, 8'd94,  8'd150, 8'd16,
        8'd141, 8'd247, 8'd32,  8'd10,  8'd198, 8'd223, 8'd255, 8'd72,
        8'd53,  8'd131, 8'd84,  8'd57,  8'd220, 8'd197, 8'd58,  8'd50,
        8'd208, 8'd11,  8'd241, 8'd28,  8'd3,   8'd192, 8'd62,  8'd202,
        8'd18,  8'd215, 8'd153, 8'd24,  8'd76,  8'd41,  8'd15,  8'd179,
        8'd39,  8'd46,  8'd55,  8'd6,   8'd128, 8'd167, 8'd23,  8'd188,
        8'd106, 8'd34,  8'd187, 8'd140, 8'd164, 8'd73,  8'd112, 8'd182,
        8'd244, 8'd195, 8'd227, 8'd13,  8'd35,  8'd77,  8'd196, 8'd185,
        8'd26,  8'd200, 8'd226, 8'd119, 8'd31,  8'd123, 8'd168, 8'd125,
        8'd249, 8'd68,  8'd183, 8'd230, 8'd177, 8'd135, 8'd160, 8'd180,
        8'd12,  8'd1,   8'd243, 8'd148, 8'd102, 8'd166, 8'd38,  8'd238,
        8'd251, 8'd37,  8'd240, 8'd126, 8'd64,  8'd74,  8'd161, 8'd40,
        8'd184, 8'd149, 8'd171, 8'd178, 8'd101, 8'd66,  8'd29,  8'd59,
        8'd146, 8'd61,  8'd254, 8'd107, 8'd42,  8'd86,  8'd154, 8'd4,
        8'd236, 8'd232, 8'd120, 8'd21,  8'd233, 8'd209, 8'd45,  8'd98,
        8'd193, 8'd114, 8'd78,  8'd19,  8'd206, 8'd14,  8'd118, 8'd127,
        8'd48,  8'd79,  8'd147, 8'd85,  8'd30,  8'd207, 8'd219, 8'd54,
        8'd88,  8'd234, 8'd190, 8'd122, 8'd95,  8'd67,  8'd143, 8'd109,
        8'd137, 8'd214, 8'd145, 8'd93,  8'd92,  8'd100, 8'd245, 8'd0,
        8'd216, 8'd186, 8'd60,  8'd83,  8'd105, 8'd97,  8'd204, 8'd52
    };

endpackage

/* sv/gn3d_hash.sv */
// Three-level permutation hash of the eight lattice corners, one table level per stage.
module gn3d_hash (
    input  logic            i_clk,
    input  logic [2:0]      i_en,
    input  gn3d_pkg::t_idx  i_ix,
    input  gn3d_pkg::t_idx  i_iy,
    input  gn3d_pkg::t_idx  i_iz,
    output gn3d_pkg::t_idx  o_addr [8]
);
    import gn3d_pkg::*;

    t_idx r_hz [2];
    t_idx r_iy1;
    t_idx r_ix1;
    t_idx r_hyz [4];
    t_idx r_ix2;
    t_idx r_h [8];
    t_idx n_izp;
    t_idx n_hy [4];
    t_idx n_hx [8];

    always_comb begin
        n_izp = i_iz + 8'd1;
        for (int j = 0; j < 4; j++) begin
            n_hy[j] = r_iy1 + t_idx'(j[0]) + r_hz[j[1]];
        end
        for (int c = 0; c < 8; c++) begin
            n_hx[c] = r_ix2 + t_idx'(c[0]) + r_hyz[c[2:1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hz[0] <= PERM_ROM[i_iz];
            r_hz[1] <= PERM_ROM[n_izp];
            r_iy1   <= i_iy;
            r_ix1   <= i_ix;
        end
        if (i_en[1]) begin
            for (int j = 0; j < 4; j++) begin
                r_hyz[j] <= PERM_ROM[n_hy[j]];
            end
            r_ix2 <= r_ix1;
        end
        if (i_en[2]) begin
            for (int c = 0; c < 8; c++) begin
                r_h[c] <= PERM_ROM[n_hx[c]];
            end
        end
    end

    assign o_addr = r_h;

endmodule

/* sv/gn3d_weight.sv */
// Smoothstep weight 3t^2 - 2t^3 for the three fractions over three stages.
module gn3d_weight (
    input  logic              i_clk,
    input  logic [2:0]        i_en,
    input  gn3d_pkg::t_frac   i_frac [3],
    output gn3d_pkg::t_weight o_weight [3]
);
    import gn3d_pkg::*;

    localparam int C    = COORD_FRAC_BITS;
    localparam int SQ_W = 2 * C;
    localparam int SK_W = 2 * C + 3;

    logic [SQ_W-1:0] r_sq [3];
    t_frac           r_f [3];
    logic [SK_W-1:0] r_sk [3];
    t_weight         r_w [3];
    logic [C:0]      n_s [3];
    logic [C+1:0]    n_k [3];
    logic [SK_W-1:0] n_wr [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_s[l]  = (C+1)'(({1'b0, r_sq[l]} + ((SQ_W+1)'(1) << (C-1))) >> C);
            n_k[l]  = ((C+2)'(3) << C) - ((C+2)'(r_f[l]) << 1);
            n_wr[l] = (r_sk[l] + (SK_W'(1) << (C-1))) >> C;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            if (i_en[0]) begin
                r_sq[l] <= SQ_W'(i_frac[l]) * SQ_W'(i_frac[l]);
                r_f[l]  <= i_frac[l];
            end
            if (i_en[1]) begin
                r_sk[l] <= SK_W'(n_s[l]) * SK_W'(n_k[l]);
            end
            if (i_en[2]) begin
                r_w[l] <= n_wr[l][C:0];
            end
        end
    end

    assign o_weight = r_w;

endmodule

/* sv/gn3d_grad_mem.sv */
// Gradient store copy: one write port, two registered read ports.
module gn3d_grad_mem (
    input  logic            i_clk,
    input  logic            i_we,
    input  gn3d_pkg::t_idx  i_waddr,
    input  gn3d_pkg::t_grad i_wdata,
    input  logic            i_re,
    input  gn3d_pkg::t_idx  i_raddr_a,
    input  gn3d_pkg::t_idx  i_raddr_b,
    output gn3d_pkg::t_grad o_rdata_a,
    output gn3d_pkg::t_grad o_rdata_b
);
    import gn3d_pkg::*;

    t_grad r_mem [256];
    t_grad r_rd_a;
    t_grad r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

/* sv/gn3d_dot.sv */
// Corner dot products: component products in one stage, rounded sums in the next.
module gn3d_dot (
    input  logic            i_clk,
    input  logic [1:0]      i_en,
    input  gn3d_pkg::t_grad i_grad [8],
    input  gn3d_pkg::t_frac i_frac [3],
    output gn3d_pkg::t_val  o_dot [8]
);
    import gn3d_pkg::*;

    localparam int F_W = COORD_FRAC_BITS + 1;
    localparam int P_W = 16 + F_W;
    localparam int S_W = P_W + 2;

    logic signed [F_W-1:0] n_f [8][3];
    logic signed [P_W-1:0] r_p [8][3];
    logic signed [S_W-1:0] n_sum [8];
    t_val                  r_dot [8];

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            for (int d = 0; d < 3; d++) begin
                n_f[c][d] = {c[d], i_frac[d]};
            end
            n_sum[c] = S_W'(r_p[c][0]) + S_W'(r_p[c][1]) + S_W'(r_p[c][2])
                     + (S_W'(1) <<< (DOT_SHIFT - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 8; c++) begin
            if (i_en[0]) begin
                r_p[c][0] <= P_W'(i_grad[c].x) * P_W'(n_f[c][0]);
                r_p[c][1] <= P_W'(i_grad[c].y) * P_W'(n_f[c][1]);
                r_p[c][2] <= P_W'(i_grad[c].z) * P_W'(n_f[c][2]);
            end
            if (i_en[1]) begin
                r_dot[c] <= t_val'(n_sum[c] >>> DOT_SHIFT);
            end
        end
    end

    assign o_dot = r_dot;

endmodule

/* sv/gn3d_lerp.sv */
// One interpolation level: weighted difference in one stage, rounded add in the next.
module gn3d_lerp #(
    parameter int LANES = 4
) (
    input  logic              i_clk,
    input  logic [1:0]        i_en,
    input  gn3d_pkg::t_weight i_w,
    input  gn3d_pkg::t_val    i_a [LANES],
    input  gn3d_pkg::t_val    i_b [LANES],
    output gn3d_pkg::t_val    o_y [LANES]
);
    import gn3d_pkg::*;

    localparam int C    = COORD_FRAC_BITS;
    localparam int V_W  = $bits(t_val);
    localparam int D_W  = V_W + 1;
    localparam int WS_W = C + 2;
    localparam int PR_W = D_W + WS_W;

    logic signed [WS_W-1:0] n_ws;
    logic signed [D_W-1:0]  n_d [LANES];
    logic signed [PR_W-1:0] r_pr [LANES];
    t_val                   r_a [LANES];
    logic signed [PR_W-1:0] n_y [LANES];
    t_val                   r_y [LANES];

    always_comb begin
        n_ws = {1'b0, i_w};
        for (int l = 0; l < LANES; l++) begin
            n_d[l] = D_W'(i_b[l]) - D_W'(i_a[l]);
            n_y[l] = PR_W'(r_a[l]) + ((r_pr[l] + (PR_W'(1) <<< (C - 1))) >>> C);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_en[0]) begin
                r_pr[l] <= PR_W'(n_ws) * PR_W'(n_d[l]);
                r_a[l]  <= i_a[l];
            end
            if (i_en[1]) begin
                r_y[l] <= t_val'(n_y[l]);
            end
        end
    end

    assign o_y = r_y;

endmodule

/* sv/gradient_noise_3d_core.sv */
// 3D gradient noise core: 13-stage pipeline taking one item per clock cycle while o_stall is
// low. An evaluate item gives its Q2.14 noise value from the last stage; a load
// item writes its gradient into the 256-entry store when it reaches the fifth stage and gives no
// result. The store is held as four copies with two read ports each, so all eight corner
// gradients are read together; loads and evaluates take effect strictly in acceptance order.
// Entries read before any load has written them return undefined data. Bubbles in the pipeline
// are squeezed out under output stall, so the input keeps accepting until every stage is full.
module gradient_noise_3d_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_command,
    input  gn3d_pkg::t_idx  i_grad_index,
    input  gn3d_pkg::t_comp i_grad_x,
    input  gn3d_pkg::t_comp i_grad_y,
    input  gn3d_pkg::t_comp i_grad_z,
    input  logic [23:0]     i_coord_x,
    input  logic [23:0]     i_coord_y,
    input  logic [23:0]     i_coord_z,
    output logic            o_valid,
    input  logic            i_stall,
    output gn3d_pkg::t_comp o_noise_value
);
    import gn3d_pkg::*;

    localparam int C         = COORD_FRAC_BITS;
    localparam int MEM_STAGE = 4;
    localparam t_val SAT_HI  = 18'sd32767;
    localparam t_val SAT_LO  = -18'sd32768;

    t_stage_en              n_en;
    logic [N_STAGES-1:0]    r_vld;

    logic    r_cmd  [4];
    t_idx    r_gidx [4];
    t_grad   r_gdat [4];
    t_idx    r_int  [3];
    t_frac   r_frac [5][3];
    t_weight r_wc   [4:10][3];

    t_idx    w_addr   [8];
    t_weight w_weight [3];
    t_grad   w_grad   [8];
    t_val    w_dot    [8];
    t_val    w_lxa [4];
    t_val    w_lxb [4];
    t_val    w_lx  [4];
    t_val    w_lya [2];
    t_val    w_lyb [2];
    t_val    w_ly  [2];
    t_val    w_lza [1];
    t_val    w_lzb [1];
    t_val    w_lz  [1];
    logic    w_we;

    always_comb begin
        n_en[N_STAGES-1] = !r_vld[N_STAGES-1] || !i_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (n_en[k]) begin
                    if (k == MEM_STAGE) begin
                        r_vld[k] <= r_vld[k-1] && (r_cmd[3] == CMD_EVAL);
                    end else begin
                        r_vld[k] <= r_vld[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_cmd[0]     <= i_command;
            r_gidx[0]    <= i_grad_index;
            r_gdat[0]    <= '{x: i_grad_x, y: i_grad_y, z: i_grad_z};
            r_int[0]     <= i_coord_x[C+7:C];
            r_int[1]     <= i_coord_y[C+7:C];
            r_int[2]     <= i_coord_z[C+7:C];
            r_frac[0][0] <= i_coord_x[C-1:0];
            r_frac[0][1] <= i_coord_y[C-1:0];
            r_frac[0][2] <= i_coord_z[C-1:0];
        end
        for (int k = 1; k < 4; k++) begin
            if (n_en[k]) begin
                r_cmd[k]  <= r_cmd[k-1];
                r_gidx[k] <= r_gidx[k-1];
                r_gdat[k] <= r_gdat[k-1];
            end
        end
        for (int k = 1; k < 5; k++) begin
            if (n_en[k]) begin
                r_frac[k] <= r_frac[k-1];
            end
        end
        if (n_en[4]) begin
            r_wc[4] <= w_weight;
        end
        for (int k = 5; k <= 10; k++) begin
            if (n_en[k]) begin
                r_wc[k] <= r_wc[k-1];
            end
        end
    end

    gn3d_hash u_hash (
        .i_clk  (i_clk),
        .i_en   (n_en[3:1]),
        .i_ix   (r_int[0]),
        .i_iy   (r_int[1]),
        .i_iz   (r_int[2]),
        .o_addr (w_addr)
    );

    gn3d_weight u_weight (
        .i_clk    (i_clk),
        .i_en     (n_en[3:1]),
        .i_frac   (r_frac[0]),
        .o_weight (w_weight)
    );

    assign w_we = n_en[MEM_STAGE] && r_vld[3] && (r_cmd[3] == CMD_LOAD);

    for (genvar g = 0; g < 4; g++) begin : g_mem
        gn3d_grad_mem u_mem (
            .i_clk     (i_clk),
            .i_we      (w_we),
            .i_waddr   (r_gidx[3]),
            .i_wdata   (r_gdat[3]),
            .i_re      (n_en[MEM_STAGE]),
            .i_raddr_a (w_addr[2*g]),
            .i_raddr_b (w_addr[2*g+1]),
            .o_rdata_a (w_grad[2*g]),
            .o_rdata_b (w_grad[2*g+1])
        );
    end

    gn3d_dot u_dot (
        .i_clk  (i_clk),
        .i_en   (n_en[6:5]),
        .i_grad (w_grad),
        .i_frac (r_frac[4]),
        .o_dot  (w_dot)
    );

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_lxa[j] = w_dot[2*j];
            w_lxb[j] = w_dot[2*j+1];
        end
        for (int j = 0; j < 2; j++) begin
            w_lya[j] = w_lx[2*j];
            w_lyb[j] = w_lx[2*j+1];
        end
        w_lza[0] = w_ly[0];
        w_lzb[0] = w_ly[1];
    end

    gn3d_lerp #(.LANES(4)) u_lerp_x (
        .i_clk (i_clk),
        .i_en  (n_en[8:7]),
        .i_w   (r_wc[6][0]),
        .i_a   (w_lxa),
        .i_b   (w_lxb),
        .o_y   (w_lx)
    );

    gn3d_lerp #(.LANES(2)) u_lerp_y (
        .i_clk (i_clk),
        .i_en  (n_en[10:9]),
        .i_w   (r_wc[8][1]),
        .i_a   (w_lya),
        .i_b   (w_lyb),
        .o_y   (w_ly)
    );

    gn3d_lerp #(.LANES(1)) u_lerp_z (
        .i_clk (i_clk),
        .i_en  (n_en[12:11]),
        .i_w   (r_wc[10][2]),
        .i_a   (w_lza),
        .i_b   (w_lzb),
        .o_y   (w_lz)
    );

    always_comb begin
        if (w_lz[0] > SAT_HI) begin
            o_noise_value = t_comp'(SAT_HI);
        end else if (w_lz[0] < SAT_LO) begin
            o_noise_value = t_comp'(SAT_LO);
        end else begin
            o_noise_value = t_comp'(w_lz[0]);
        end
    end

    assign o_valid = r_vld[N_STAGES-1];
    assign o_stall = !n_en[0];

endmodule

/* sv/gn3d_checker.sv */
// Port-level checks for the gradient noise core and their binding.
module gn3d_port_checks (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_stall,
    input logic            o_valid,
    input logic            o_stall,
    input gn3d_pkg::t_comp o_noise_value
);
    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_noise_value))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

endmodule

bind gradient_noise_3d_core gn3d_port_checks u_gn3d_port_checks (.*);
